// File: rtl/kissfp_pkg.sv
// Shared types, KISS byte codes and frame length helpers for the KISS frame packer.
`default_nettype none

package kissfp_pkg;

    localparam int MAX_FRAME_LEN = 64;
    localparam int MIN_FRAME_LEN = 4;
    localparam int LEN_W         = 7;

    localparam logic [LEN_W-1:0] FRAME_LEN_RESET = LEN_W'(64);

    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       final_frame;
        logic       last;
    } out_item_t;

    // Clamp the programmed length into the supported frame range.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] s;
        s = len;
        if (len < LEN_W'(MIN_FRAME_LEN))
            s = LEN_W'(MIN_FRAME_LEN);
        else if (len > LEN_W'(MAX_FRAME_LEN))
            s = LEN_W'(MAX_FRAME_LEN);
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kiss_fixed_frame_packer.sv
// KISS fixed-length frame packer: byte-at-a-time sequencer with one shared counter and compare.
// Ordering: an accepted item is registered first; its first output byte is then loaded into the
//   output register once the output slot is free (after the P_DEC check for an escaped byte on an open frame).
// Throughput: one output byte per cycle within an item while out_stall is low; in_stall holds
//   the input until the sequencer has sent every byte of the current item and returned to idle.
// Reset: frame_length returns to 64, no frame is open, the output register is empty.
`default_nettype none

module kiss_fixed_frame_packer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire kissfp_pkg::in_item_t         in_item,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output kissfp_pkg::out_item_t             out_item,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [kissfp_pkg::LEN_W-1:0] cfg_data
);
    import kissfp_pkg::*;

    // Sequencer phases; each emitting phase puts out exactly one byte.
    localparam logic [3:0] P_IDLE  = 4'd0;
    localparam logic [3:0] P_DEC   = 4'd1;  // special byte on open frame: does the pair fit
    localparam logic [3:0] P_OPEN  = 4'd2;  // opening FEND
    localparam logic [3:0] P_SPL1  = 4'd3;  // first closing FEND of a split
    localparam logic [3:0] P_SPL2  = 4'd4;  // second closing FEND of a split, ends frame
    localparam logic [3:0] P_ESC1  = 4'd5;  // FESC
    localparam logic [3:0] P_ESC2  = 4'd6;  // TFEND or TFESC
    localparam logic [3:0] P_DATA  = 4'd7;  // plain payload byte
    localparam logic [3:0] P_CLOSE = 4'd8;  // closing FEND after frame fills
    localparam logic [3:0] P_PAD   = 4'd9;  // end-of-data padding

    logic [3:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] bif_reg, bif_next;       // bytes already sent in the open frame
    logic             open_reg, open_next;
    logic [LEN_W-1:0] frame_length_reg;

    logic [7:0]       data_reg;
    logic             special_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic             in_accept;
    logic             in_special;
    logic             slot_free;
    logic             emit;
    out_item_t        emit_item;

    // Shared arithmetic: one incrementer and one compare against S-1 or S-2.
    logic [LEN_W-1:0] s_len;
    logic [LEN_W-1:0] thr;
    logic [LEN_W-1:0] bif_inc;
    logic             cmp_ge;

    assign s_len   = eff_len(frame_length_reg);
    assign thr     = (phase_reg == P_PAD) ? (s_len - LEN_W'(1)) : (s_len - LEN_W'(2));
    assign cmp_ge  = (bif_reg >= thr);
    assign bif_inc = bif_reg + LEN_W'(1);

    assign in_stall   = (phase_reg != P_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign in_special = (in_item.data_byte == KISS_FEND) || (in_item.data_byte == KISS_FESC);
    assign slot_free  = !out_valid_reg || !out_stall;
    assign cfg_ready  = (phase_reg == P_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    always_comb
    begin
        phase_next = phase_reg;
        bif_next   = bif_reg;
        open_next  = open_reg;
        emit       = 1'b0;
        emit_item  = '{out_byte: KISS_FEND, frame_end: 1'b0, final_frame: 1'b0, last: 1'b0};

        case (phase_reg)
            P_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.req_type == REQ_END)
                        phase_next = P_PAD;
                    else if (!open_reg)
                        phase_next = P_OPEN;
                    else if (in_special)
                        phase_next = P_DEC;
                    else
                        phase_next = P_DATA;
                end
            end
            P_DEC:
            begin
                phase_next = cmp_ge ? P_SPL1 : P_ESC1;
            end
            P_OPEN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    bif_next   = LEN_W'(1);
                    open_next  = 1'b1;
                    // a fresh frame always has room for an escape pair
                    phase_next = special_reg ? P_ESC1 : P_DATA;
                end
            end
            P_SPL1:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    phase_next = P_SPL2;
                end
            end
            P_SPL2:
            begin
                if (slot_free)
                begin
                    emit                = 1'b1;
                    emit_item.frame_end = 1'b1;
                    bif_next            = '0;
                    open_next           = 1'b0;
                    phase_next          = P_OPEN;
                end
            end
            P_ESC1:
            begin
                if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_item.out_byte = KISS_FESC;
                    bif_next           = bif_inc;
                    phase_next         = P_ESC2;
                end
            end
            P_ESC2, P_DATA:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (phase_reg == P_DATA)
                        emit_item.out_byte = data_reg;
                    else
                        emit_item.out_byte = (data_reg == KISS_FEND) ? KISS_TFEND : KISS_TFESC;
                    bif_next = bif_inc;
                    // count after this byte >= S-1  <=>  count now >= S-2
                    if (cmp_ge)
                        phase_next = P_CLOSE;
                    else
                    begin
                        emit_item.last = 1'b1;
                        phase_next     = P_IDLE;
                    end
                end
            end
            P_CLOSE:
            begin
                if (slot_free)
                begin
                    emit                = 1'b1;
                    emit_item.frame_end = 1'b1;
                    emit_item.last      = 1'b1;
                    bif_next            = '0;
                    open_next           = 1'b0;
                    phase_next          = P_IDLE;
                end
            end
            P_PAD:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    emit_item.final_frame = 1'b1;
                    // last pad byte once the count reaches S-1 (or an oversized frame)
                    if (cmp_ge)
                    begin
                        emit_item.frame_end = 1'b1;
                        emit_item.last      = 1'b1;
                        bif_next            = '0;
                        open_next           = 1'b0;
                        phase_next          = P_IDLE;
                    end
                    else
                    begin
                        // the pad frame counts as open until its closing FEND
                        bif_next  = bif_inc;
                        open_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= P_IDLE;
            bif_reg          <= '0;
            open_reg         <= 1'b0;
            frame_length_reg <= FRAME_LEN_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            open_reg  <= open_next;
            if (cfg_valid && cfg_ready)
                frame_length_reg <= cfg_data;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_reg    <= in_item.data_byte;
            special_reg <= in_special;
        end
        if (emit)
            out_item_reg <= emit_item;
    end

    // The open flag and the byte count always agree.
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == (bif_reg != '0))
        else $error("frame open flag disagrees with byte count");

    // The count never runs past the largest frame.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        bif_reg <= LEN_W'(MAX_FRAME_LEN))
        else $error("byte count beyond maximum frame length");

    // A byte that ends a frame leaves no frame open.
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_item.frame_end |=> !open_reg)
        else $error("frame still open after frame end byte");

    // The last byte of an item returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_item.last |=> phase_reg == P_IDLE)
        else $error("sequencer busy after last byte");

    // Only end-of-data padding carries the final flag.
    a_final_pad: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_item.final_frame |-> phase_reg == P_PAD)
        else $error("final flag outside padding");

endmodule

`default_nettype wire
